[rtl/bcdas_pkg.sv]
// ----------------------------------------------------------------------------
// bcdas_pkg: shared definitions for the BCD add/subtract unit
// Register selects, access kinds, control bit positions and defaults.
// ----------------------------------------------------------------------------
package bcdas_pkg;

    // Width of one packed-BCD word and its digit count
    localparam int WORD_W      = 32;
    localparam int DIGIT_W     = 4;
    localparam int WORD_DIGITS = WORD_W / DIGIT_W;
    localparam int CTL_W       = 16;

    // Default operation length in digits (legal range 1..8, WORD_DIGITS)
    localparam int DEF_DIGITS  = 8;

    // Control register bit positions
    localparam int CTL_OP_ADD_BIT    = 0;
    localparam int CTL_USE_LAST_BIT  = 1;
    localparam int CTL_CARRY_IN_BIT  = 2;
    localparam int CTL_CARRY_OUT_BIT = 12;

    localparam logic [3:0] BCD_MAX_DIGIT = 4'd9;
    localparam logic [3:0] BCD_RADIX     = 4'd10;

    typedef enum logic [1:0] {
        REG_CONTROL  = 2'd0,
        REG_SOURCE_A = 2'd1,
        REG_SOURCE_B = 2'd2,
        REG_RESULT   = 2'd3
    } t_reg_sel;

    typedef enum logic {
        FUNC_READ  = 1'b0,
        FUNC_WRITE = 1'b1
    } t_func;

endpackage

[rtl/bcd_add_subtract_unit.sv]
// ----------------------------------------------------------------------------
// bcd_add_subtract_unit: packed-BCD add/subtract register peripheral
// Four registers (control, source A, source B, result). A write to control
// runs a DIGITS-digit BCD add or subtract on A and B and stores the result.
// ----------------------------------------------------------------------------
//
//  channel | direction | transfer when     | payload
//  --------+-----------+-------------------+-------------------------------
//  access  | in        | i_valid & o_ready | i_func, i_reg_sel, i_write_data
//  reply   | out       | o_valid & i_ready | o_read_data
//
// The register update and the BCD carry chain settle in the cycle of the input
// transfer, and the reply is registered so it shows in the next cycle. One
// access can be taken every cycle while o_ready is high.
// A stalled reply holds the output register; o_ready drops only while a reply
// waits and i_ready is low, so a waiting reply and a new access overlap.
// Reset (synchronous, active low) clears every register but the reply data.
// The carry chain through DIGITS digits is the longest path in the block.
//
module bcd_add_subtract_unit
    import bcdas_pkg::*;
#(
    parameter int DIGITS = DEF_DIGITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_func,
    input  logic [1:0]        i_reg_sel,
    input  logic [WORD_W-1:0] i_write_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_read_data
);

    // Architectural state
    logic [CTL_W-1:0]  r_control;
    logic [WORD_W-1:0] r_source_a;
    logic [WORD_W-1:0] r_source_b;
    logic [WORD_W-1:0] r_result;
    logic              r_last_carry;

    // Reply register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_data;

    logic              n_out_valid;
    logic [WORD_W-1:0] n_out_data;

    logic              accept;
    logic              is_write;
    t_reg_sel          sel;

    logic              op_add;
    logic              carry_in;
    logic [WORD_W-1:0] bcd_sum;
    logic              bcd_cout;
    logic [CTL_W-1:0]  n_control;

    // Run the digit chain. Non-BCD digits keep their oversized or negative
    // remainder, which spills into the higher bits through the OR.
    function automatic logic [WORD_W:0] bcd_run(
        input logic              add,
        input logic              cin,
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b
    );
        logic [WORD_W-1:0]  acc;
        logic [WORD_W-1:0]  a_sh;
        logic [WORD_W-1:0]  b_sh;
        logic               c;
        logic [DIGIT_W-1:0] da;
        logic [DIGIT_W-1:0] db;
        logic signed [5:0]  d;
        logic signed [WORD_W-1:0] d_ext;
        acc  = '0;
        a_sh = a;
        b_sh = b;
        c    = cin;
        for (int i = 0; i < DIGITS; i++) begin
            da = a_sh[DIGIT_W-1:0];
            db = b_sh[DIGIT_W-1:0];
            if (add) begin
                d = $signed({2'b00, da}) + $signed({2'b00, db}) + $signed({5'd0, c});
                if (d > $signed({2'b00, BCD_MAX_DIGIT})) begin
                    d = d - $signed({2'b00, BCD_RADIX});
                    c = 1'b1;
                end else begin
                    c = 1'b0;
                end
            end else begin
                if ({1'b0, da} < ({1'b0, db} + {4'd0, c})) begin
                    d = $signed({2'b00, da}) + $signed({2'b00, BCD_RADIX})
                        - $signed({2'b00, db}) - $signed({5'd0, c});
                    c = 1'b1;
                end else begin
                    d = $signed({2'b00, da}) - $signed({2'b00, db})
                        - $signed({5'd0, c});
                    c = 1'b0;
                end
            end
            d_ext = WORD_W'(d);
            acc   = acc | WORD_W'(d_ext << (DIGIT_W * i));
            a_sh  = a_sh >> DIGIT_W;
            b_sh  = b_sh >> DIGIT_W;
        end
        return {c, acc};
    endfunction

    // Accept while no reply waits, or while the waiting one leaves
    assign o_ready  = !r_out_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign is_write = (t_func'(i_func) == FUNC_WRITE);
    assign sel      = t_reg_sel'(i_reg_sel);

    // Operation fields come straight from the control write data
    assign op_add   = i_write_data[CTL_OP_ADD_BIT];
    assign carry_in = i_write_data[CTL_CARRY_IN_BIT]
                    | (i_write_data[CTL_USE_LAST_BIT] & r_last_carry);

    assign {bcd_cout, bcd_sum} = bcd_run(op_add, carry_in, r_source_a, r_source_b);

    // Stored control word: written bit 12 is replaced by the carry out
    always_comb begin
        n_control = i_write_data[CTL_W-1:0];
        n_control[CTL_CARRY_OUT_BIT] = bcd_cout;
    end

    // Reply: register contents on read, zero on write
    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_out_data  = r_out_data;
        if (accept) begin
            n_out_valid = 1'b1;
            if (is_write) begin
                n_out_data = '0;
            end else begin
                unique case (sel)
                    REG_CONTROL:  n_out_data = WORD_W'(r_control);
                    REG_SOURCE_A: n_out_data = r_source_a;
                    REG_SOURCE_B: n_out_data = r_source_b;
                    REG_RESULT:   n_out_data = r_result;
                    default:      n_out_data = '0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control    <= '0;
            r_source_a   <= '0;
            r_source_b   <= '0;
            r_result     <= '0;
            r_last_carry <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept && is_write) begin
                unique case (sel)
                    REG_CONTROL: begin
                        r_control    <= n_control;
                        r_result     <= bcd_sum;
                        r_last_carry <= bcd_cout;
                    end
                    REG_SOURCE_A: r_source_a <= i_write_data;
                    REG_SOURCE_B: r_source_b <= i_write_data;
                    REG_RESULT:   r_result   <= i_write_data;
                    default: begin
                        r_result <= r_result;
                    end
                endcase
            end
        end
    end

    // Payload register: no reset needed
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;

endmodule
